[sv/cjpe_pkg.sv]
package cjpe_pkg;

  localparam int unsigned RadialWidth  = 24;
  localparam int unsigned AngularWidth = 16;
  localparam int unsigned NumCfg       = 7;
  localparam int unsigned CfgIdxWidth  = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ANCHOR_A = 3'd0,
    CFG_ANCHOR_B = 3'd1,
    CFG_M_ON_A   = 3'd2,
    CFG_N_ON_A   = 3'd3,
    CFG_M_ON_B   = 3'd4,
    CFG_N_ON_B   = 3'd5,
    CFG_JOINT_A  = 3'd6
  } cfg_idx_e;

  typedef logic signed [RadialWidth-1:0]  radial_t;
  typedef logic signed [AngularWidth-1:0] angular_t;

endpackage

[sv/cjpe_in_if.sv]
interface cjpe_in_if #(
  parameter int unsigned LENGTH_WIDTH = 20,
  parameter int unsigned UNIT_WIDTH   = 16
);
  logic                      valid;
  logic                      ready;
  logic [3*LENGTH_WIDTH-1:0] body_a_position;
  logic [4*UNIT_WIDTH-1:0]   body_a_orientation;
  logic [3*LENGTH_WIDTH-1:0] body_b_position;
  logic [4*UNIT_WIDTH-1:0]   body_b_orientation;

  modport source (output valid, body_a_position, body_a_orientation, body_b_position,
                  body_b_orientation, input ready);
  modport sink (input valid, body_a_position, body_a_orientation, body_b_position,
                body_b_orientation, output ready);
endinterface

[sv/cjpe_out_if.sv]
interface cjpe_out_if;
  logic                     valid;
  logic                     ready;
  cjpe_pkg::radial_t        radial_error_m;
  cjpe_pkg::radial_t        radial_error_n;
  cjpe_pkg::angular_t       angular_error_m;
  cjpe_pkg::angular_t       angular_error_n;

  modport source (output valid, radial_error_m, radial_error_n, angular_error_m,
                  angular_error_n, input ready);
  modport sink (input valid, radial_error_m, radial_error_n, angular_error_m,
                angular_error_n, output ready);
endinterface

[sv/cjpe_quat_mat.sv]
module cjpe_quat_mat #(
  parameter int unsigned UW = 16,
  parameter int unsigned MW = UW + 4
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [4*UW-1:0]       q_i,
  output logic signed [MW-1:0]  m_o [9]
);
  localparam int unsigned UF = UW - 2;
  localparam int unsigned PW = 2*UW + 3;

  logic signed [UW-1:0]   w, x, y, z;
  logic signed [2*UW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [PW-1:0]   e [9];

  assign w = q_i[0*UW +: UW];
  assign x = q_i[1*UW +: UW];
  assign y = q_i[2*UW +: UW];
  assign z = q_i[3*UW +: UW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= x * x;  yy_q <= y * y;  zz_q <= z * z;
      xy_q <= x * y;  xz_q <= x * z;  yz_q <= y * z;
      wx_q <= w * x;  wy_q <= w * y;  wz_q <= w * z;
    end
  end

  always_comb begin
    logic signed [PW-1:0] one;
    one  = PW'(1) <<< (2*UF);
    e[0] = one - ((PW'(yy_q) + PW'(zz_q)) <<< 1);
    e[1] = (PW'(xy_q) - PW'(wz_q)) <<< 1;
    e[2] = (PW'(xz_q) + PW'(wy_q)) <<< 1;
    e[3] = (PW'(xy_q) + PW'(wz_q)) <<< 1;
    e[4] = one - ((PW'(xx_q) + PW'(zz_q)) <<< 1);
    e[5] = (PW'(yz_q) - PW'(wx_q)) <<< 1;
    e[6] = (PW'(xz_q) - PW'(wy_q)) <<< 1;
    e[7] = (PW'(yz_q) + PW'(wx_q)) <<< 1;
    e[8] = one - ((PW'(xx_q) + PW'(yy_q)) <<< 1);
  end

  // round half up to UF fraction bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        m_o[i] <= MW'((e[i] + (PW'(1) <<< (UF-1))) >>> UF);
      end
    end
  end
endmodule

[sv/cjpe_rotate.sv]
module cjpe_rotate #(
  parameter int unsigned UW = 16,
  parameter int unsigned MW = UW + 4,
  parameter int unsigned VW = 16,
  parameter int unsigned RW = MW + VW + 3 - (UW - 2)
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [MW-1:0]  m_i [9],
  input  logic [3*VW-1:0]       v_i,
  output logic signed [RW-1:0]  r_o [3]
);
  localparam int unsigned UF = UW - 2;
  localparam int unsigned PW = MW + VW;
  localparam int unsigned SW = PW + 3;

  logic signed [PW-1:0] p_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_q[3*i+j] <= m_i[3*i+j] * $signed(v_i[j*VW +: VW]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        r_o[i] <= RW'((SW'(p_q[3*i]) + SW'(p_q[3*i+1]) + SW'(p_q[3*i+2])
                       + (SW'(1) <<< (UF-1))) >>> UF);
      end
    end
  end
endmodule

[sv/cjpe_dot.sv]
module cjpe_dot #(
  parameter int unsigned UW = 16,
  parameter int unsigned AW = 25,
  parameter int unsigned BW = 25,
  parameter int unsigned OW = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [AW-1:0]  a_i [3],
  input  logic signed [BW-1:0]  b_i [3],
  output logic signed [OW-1:0]  r_o
);
  localparam int unsigned UF = UW - 2;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned SW = PW + 3;

  logic signed [PW-1:0] p_q [3];
  logic signed [SW-1:0] rnd;
  logic signed [SW-1:0] hi, lo;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= a_i[i] * b_i[i];
      end
    end
  end

  assign rnd = (SW'(p_q[0]) + SW'(p_q[1]) + SW'(p_q[2]) + (SW'(1) <<< (UF-1))) >>> UF;
  assign hi  = (SW'(1) <<< (OW-1)) - SW'(1);
  assign lo  = -hi - SW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rnd > hi) begin
        r_o <= OW'(hi);
      end else if (rnd < lo) begin
        r_o <= OW'(lo);
      end else begin
        r_o <= OW'(rnd);
      end
    end
  end
endmodule

[sv/cylindrical_joint_position_error_unit.sv]
// channel   dir  handshake      payload
// in_i      in   valid/ready    body a/b position, body a/b orientation
// out_o     out  valid/ready    radial errors m/n, angular errors m/n
// cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// one transaction per cycle unless stalled, through a seven-stage pipeline
// (quaternion products, matrix, rotate products, rotate sums, separation,
// dot products, round and saturate). the whole pipeline advances together
// whenever the output register is empty or taken, so a stall freezes it.
// reset clears the valid bits and the configuration registers.
module cylindrical_joint_position_error_unit #(
  parameter int unsigned LENGTH_WIDTH = 20,
  parameter int unsigned UNIT_WIDTH   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  cjpe_in_if.sink                               in_i,
  cjpe_out_if.source                            out_o,
  input  logic                                  cfg_we_i,
  input  logic [cjpe_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [((3*LENGTH_WIDTH > 3*UNIT_WIDTH) ? 3*LENGTH_WIDTH : 3*UNIT_WIDTH)-1:0]
                                                cfg_data_i
);
  import cjpe_pkg::*;

  localparam int unsigned LW   = LENGTH_WIDTH;
  localparam int unsigned UW   = UNIT_WIDTH;
  localparam int unsigned UF   = UW - 2;
  localparam int unsigned MW   = UW + 4;
  localparam int unsigned RWL  = MW + LW + 3 - UF;
  localparam int unsigned RWU  = MW + UW + 3 - UF;
  localparam int unsigned DW   = RWL + 2;
  localparam int unsigned NSTG = 7;

  logic [3*LW-1:0] anchor_a_q, anchor_b_q;
  logic [3*UW-1:0] m_a_q, n_a_q, m_b_q, n_b_q, joint_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_a_q <= '0;
      anchor_b_q <= '0;
      m_a_q      <= '0;
      n_a_q      <= '0;
      m_b_q      <= '0;
      n_b_q      <= '0;
      joint_a_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ANCHOR_A: anchor_a_q <= cfg_data_i[3*LW-1:0];
        CFG_ANCHOR_B: anchor_b_q <= cfg_data_i[3*LW-1:0];
        CFG_M_ON_A:   m_a_q      <= cfg_data_i[3*UW-1:0];
        CFG_N_ON_A:   n_a_q      <= cfg_data_i[3*UW-1:0];
        CFG_M_ON_B:   m_b_q      <= cfg_data_i[3*UW-1:0];
        CFG_N_ON_B:   n_b_q      <= cfg_data_i[3*UW-1:0];
        CFG_JOINT_A:  joint_a_q  <= cfg_data_i[3*UW-1:0];
        default: ;
      endcase
    end
  end

  logic            adv;
  logic [NSTG-1:0] vld_q;

  assign adv         = !vld_q[NSTG-1] || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  // positions wait alongside matrix and rotation stages
  logic [3*LW-1:0] pos_a_q [4];
  logic [3*LW-1:0] pos_b_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_a_q[0] <= in_i.body_a_position;
      pos_b_q[0] <= in_i.body_b_position;
      for (int i = 1; i < 4; i++) begin
        pos_a_q[i] <= pos_a_q[i-1];
        pos_b_q[i] <= pos_b_q[i-1];
      end
    end
  end

  logic signed [MW-1:0] ra [9];
  logic signed [MW-1:0] rb [9];

  cjpe_quat_mat #(.UW(UW), .MW(MW)) u_mat_a (
    .clk_i, .en_i(adv), .q_i(in_i.body_a_orientation), .m_o(ra)
  );
  cjpe_quat_mat #(.UW(UW), .MW(MW)) u_mat_b (
    .clk_i, .en_i(adv), .q_i(in_i.body_b_orientation), .m_o(rb)
  );

  logic signed [RWL-1:0] pa [3];
  logic signed [RWL-1:0] pb [3];
  logic signed [RWU-1:0] ma [3];
  logic signed [RWU-1:0] na [3];
  logic signed [RWU-1:0] mb [3];
  logic signed [RWU-1:0] nb [3];
  logic signed [RWU-1:0] ax [3];

  cjpe_rotate #(.UW(UW), .MW(MW), .VW(LW), .RW(RWL)) u_rot_pa (
    .clk_i, .en_i(adv), .m_i(ra), .v_i(anchor_a_q), .r_o(pa)
  );
  cjpe_rotate #(.UW(UW), .MW(MW), .VW(LW), .RW(RWL)) u_rot_pb (
    .clk_i, .en_i(adv), .m_i(rb), .v_i(anchor_b_q), .r_o(pb)
  );
  cjpe_rotate #(.UW(UW), .MW(MW), .VW(UW), .RW(RWU)) u_rot_ma (
    .clk_i, .en_i(adv), .m_i(ra), .v_i(m_a_q), .r_o(ma)
  );
  cjpe_rotate #(.UW(UW), .MW(MW), .VW(UW), .RW(RWU)) u_rot_na (
    .clk_i, .en_i(adv), .m_i(ra), .v_i(n_a_q), .r_o(na)
  );
  cjpe_rotate #(.UW(UW), .MW(MW), .VW(UW), .RW(RWU)) u_rot_mb (
    .clk_i, .en_i(adv), .m_i(rb), .v_i(m_b_q), .r_o(mb)
  );
  cjpe_rotate #(.UW(UW), .MW(MW), .VW(UW), .RW(RWU)) u_rot_nb (
    .clk_i, .en_i(adv), .m_i(rb), .v_i(n_b_q), .r_o(nb)
  );
  cjpe_rotate #(.UW(UW), .MW(MW), .VW(UW), .RW(RWU)) u_rot_ax (
    .clk_i, .en_i(adv), .m_i(ra), .v_i(joint_a_q), .r_o(ax)
  );

  // separation stage; axes are registered alongside it to stay aligned
  logic signed [DW-1:0]  d_q  [3];
  logic signed [RWU-1:0] ma_q [3];
  logic signed [RWU-1:0] na_q [3];
  logic signed [RWU-1:0] mb_q [3];
  logic signed [RWU-1:0] nb_q [3];
  logic signed [RWU-1:0] ax_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i]  <= DW'($signed(pos_b_q[3][i*LW +: LW])) + DW'(pb[i])
                 - DW'($signed(pos_a_q[3][i*LW +: LW])) - DW'(pa[i]);
        ma_q[i] <= ma[i];
        na_q[i] <= na[i];
        mb_q[i] <= mb[i];
        nb_q[i] <= nb[i];
        ax_q[i] <= ax[i];
      end
    end
  end

  cjpe_dot #(.UW(UW), .AW(RWU), .BW(DW), .OW(RadialWidth)) u_dot_rm (
    .clk_i, .en_i(adv), .a_i(ma_q), .b_i(d_q), .r_o(out_o.radial_error_m)
  );
  cjpe_dot #(.UW(UW), .AW(RWU), .BW(DW), .OW(RadialWidth)) u_dot_rn (
    .clk_i, .en_i(adv), .a_i(na_q), .b_i(d_q), .r_o(out_o.radial_error_n)
  );
  cjpe_dot #(.UW(UW), .AW(RWU), .BW(RWU), .OW(AngularWidth)) u_dot_am (
    .clk_i, .en_i(adv), .a_i(mb_q), .b_i(ax_q), .r_o(out_o.angular_error_m)
  );
  cjpe_dot #(.UW(UW), .AW(RWU), .BW(RWU), .OW(AngularWidth)) u_dot_an (
    .clk_i, .en_i(adv), .a_i(nb_q), .b_i(ax_q), .r_o(out_o.angular_error_n)
  );

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_last_stage_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[NSTG-2] |=> out_o.valid)
    else $error("transaction lost before the output register");
endmodule

[tb/sv/tb_cylindrical_joint_position_error_unit.sv]
`timescale 1ns / 100ps

module tb_cylindrical_joint_position_error_unit;
  import cjpe_pkg::*;

  localparam int unsigned LW = 20;
  localparam int unsigned UW = 16;
  localparam int unsigned UFB = UW - 2;
  localparam int unsigned CfgW = 3 * LW;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [3*LW-1:0] pos_a;
    logic [4*UW-1:0] quat_a;
    logic [3*LW-1:0] pos_b;
    logic [4*UW-1:0] quat_b;
  } bodies_t;

  typedef struct packed {
    radial_t  rad_m;
    radial_t  rad_n;
    angular_t ang_m;
    angular_t ang_n;
  } joint_err_t;

  typedef longint mat3_t [3][3];
  typedef longint vec3_t [3];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  cjpe_in_if #(.LENGTH_WIDTH(LW), .UNIT_WIDTH(UW)) in_ch ();
  cjpe_out_if out_ch ();

  cylindrical_joint_position_error_unit #(.LENGTH_WIDTH(LW), .UNIT_WIDTH(UW)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [CfgW-1:0] joint_regs [NumCfg];
  bodies_t pending_bodies [$];
  joint_err_t expected_errs [$];
  int n_mismatch = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  bit drive_hold = 1'b0;
  bit long_stall_req = 1'b0;
  bit in_fire = 1'b0;

  function automatic longint sx(logic [63:0] packed_v, int idx, int w);
    logic [63:0] u;
    u = (packed_v >> (idx * w)) & ((64'd1 << w) - 1);
    if (u[w-1]) return longint'(u) - (longint'(1) <<< w);
    return longint'(u);
  endfunction

  // round half up: floor(v/2^s + 1/2)
  function automatic longint rhu(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clampw(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic mat3_t quat_rot(logic [4*UW-1:0] q);
    longint w, x, y, z, one;
    mat3_t m;
    w = sx(q, 0, UW); x = sx(q, 1, UW); y = sx(q, 2, UW); z = sx(q, 3, UW);
    one = longint'(1) <<< (2 * UFB);
    m[0][0] = rhu(one - 2 * (y * y + z * z), UFB);
    m[0][1] = rhu(2 * (x * y - w * z), UFB);
    m[0][2] = rhu(2 * (x * z + w * y), UFB);
    m[1][0] = rhu(2 * (x * y + w * z), UFB);
    m[1][1] = rhu(one - 2 * (x * x + z * z), UFB);
    m[1][2] = rhu(2 * (y * z - w * x), UFB);
    m[2][0] = rhu(2 * (x * z - w * y), UFB);
    m[2][1] = rhu(2 * (y * z + w * x), UFB);
    m[2][2] = rhu(one - 2 * (x * x + y * y), UFB);
    return m;
  endfunction

  function automatic vec3_t rot_vec(mat3_t m, logic [63:0] packed_v, int w);
    vec3_t v, r;
    for (int i = 0; i < 3; i++) v[i] = sx(packed_v, i, w);
    for (int i = 0; i < 3; i++) r[i] = rhu(m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2], UFB);
    return r;
  endfunction

  function automatic longint dot3(vec3_t a, vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic joint_err_t joint_errors(bodies_t b);
    mat3_t ra, rb;
    vec3_t pa, pb, d, ma, na, mb, nb, ax;
    joint_err_t e;
    ra = quat_rot(b.quat_a);
    rb = quat_rot(b.quat_b);
    pa = rot_vec(ra, joint_regs[CFG_ANCHOR_A], LW);
    pb = rot_vec(rb, joint_regs[CFG_ANCHOR_B], LW);
    for (int i = 0; i < 3; i++)
      d[i] = sx(b.pos_b, i, LW) + pb[i] - sx(b.pos_a, i, LW) - pa[i];
    ma = rot_vec(ra, joint_regs[CFG_M_ON_A], UW);
    na = rot_vec(ra, joint_regs[CFG_N_ON_A], UW);
    mb = rot_vec(rb, joint_regs[CFG_M_ON_B], UW);
    nb = rot_vec(rb, joint_regs[CFG_N_ON_B], UW);
    ax = rot_vec(ra, joint_regs[CFG_JOINT_A], UW);
    e.rad_m = radial_t'(clampw(rhu(dot3(ma, d), UFB), RadialWidth));
    e.rad_n = radial_t'(clampw(rhu(dot3(na, d), UFB), RadialWidth));
    e.ang_m = angular_t'(clampw(rhu(dot3(mb, ax), UFB), AngularWidth));
    e.ang_n = angular_t'(clampw(rhu(dot3(nb, ax), UFB), AngularWidth));
    return e;
  endfunction

  // whether the offered item was taken at the last rising edge
  always @(posedge clk_i) begin
    in_fire <= in_ch.valid && in_ch.ready;
  end

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // hold the offered item
    end else if (drive_hold || pending_bodies.size() == 0) begin
      in_ch.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_ch.valid <= 1'b0;
    end else begin
      {in_ch.body_a_position, in_ch.body_a_orientation, in_ch.body_b_position,
       in_ch.body_b_orientation} <= pending_bodies.pop_front();
      in_ch.valid <= 1'b1;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  int stall_phase = 0;
  int long_stall_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (long_stall_req && long_stall_left == 0) begin
      long_stall_left <= 60;
      long_stall_req <= 1'b0;
      out_ch.ready <= 1'b0;
    end else if (long_stall_left > 0) begin
      long_stall_left <= long_stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 200;
      if (stall_phase < 80) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_errs.push_back(joint_errors({in_ch.body_a_position,
          in_ch.body_a_orientation, in_ch.body_b_position, in_ch.body_b_orientation}));
        n_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        joint_err_t got, want;
        got = {out_ch.radial_error_m, out_ch.radial_error_n,
               out_ch.angular_error_m, out_ch.angular_error_n};
        if (expected_errs.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected transaction %p", got);
        end else begin
          want = expected_errs.pop_front();
          n_checked++;
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("mismatch #%0d exp %p got %p", n_checked, want, got);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("tb_cylindrical_joint_position_error_unit: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // near-unit quaternion with small random spread, sometimes bounded random, sometimes fully random
  function automatic logic [4*UW-1:0] some_quat();
    logic [4*UW-1:0] q;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return rnd64();
    if (sel < 6) begin
      for (int i = 0; i < 4; i++) q[i*UW +: UW] = UW'($urandom_range(0, 16384) - 8192);
      return q;
    end
    q = '0;
    q[($urandom_range(0, 3))*UW +: UW] = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
    for (int i = 0; i < 4; i++) q[i*UW +: UW] = q[i*UW +: UW] + UW'($urandom_range(0, 64) - 32);
    return q;
  endfunction

  function automatic logic [3*LW-1:0] some_pos();
    logic [3*LW-1:0] p;
    if ($urandom_range(0, 3) == 0) return CfgW'(rnd64());
    for (int i = 0; i < 3; i++) p[i*LW +: LW] = LW'($urandom_range(0, 40960) - 20480);
    return p;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= CFG_ANCHOR_B) joint_regs[idx] = val;
    else joint_regs[idx] = CfgW'(val & ((64'd1 << (3 * UW)) - 1));
  endtask

  task automatic drain();
    wait (pending_bodies.size() == 0 && !in_ch.valid && expected_errs.size() == 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic load_regs(int mode);
    logic [CfgW-1:0] v;
    for (int r = 0; r < NumCfg; r++) begin
      case (mode)
        0: v = '0;
        1: v = '1;
        2: v = {20'h80000, 20'h80000, 20'h80000} | {{3{16'h8000}}};
        3: v = (r <= CFG_ANCHOR_B) ? {20'h7ffff, 20'h7ffff, 20'h7ffff}
                                   : {12'h0, {3{16'h7fff}}};
        default: v = CfgW'(rnd64());
      endcase
      // a plausible set of axes for the well-formed settings
      if (mode == 5 && r >= CFG_M_ON_A) begin
        v = '0;
        v[((r - CFG_M_ON_A) % 3) * UW +: UW] = 16'sd16384;
      end
      write_reg(cfg_idx_e'(r), v);
    end
  endtask

  initial begin
    bodies_t b;
    in_ch.valid = 1'b0;
    in_ch.body_a_position = '0;
    in_ch.body_a_orientation = '0;
    in_ch.body_b_position = '0;
    in_ch.body_b_orientation = '0;
    out_ch.ready = 1'b0;
    for (int r = 0; r < NumCfg; r++) joint_regs[r] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes with random registers
    load_regs(4);
    for (int k = 0; k < 20; k++) begin
      case (k % 5)
        0: b = '0;
        1: b = '1;
        2: b = {{3{20'h80000}}, {4{16'h8000}}, {3{20'h80000}}, {4{16'h8000}}};
        3: b = {{3{20'h7ffff}}, {4{16'h7fff}}, {3{20'h7ffff}}, {4{16'h7fff}}};
        default: b = {some_pos(), 64'h0000_0000_0000_4000, some_pos(), rnd64()};
      endcase
      pending_bodies.push_back(b);
    end
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      load_regs(ph == 6 ? 5 : ph % 5 + (ph >= 5 ? 0 : 0));
      for (int k = 0; k < 200; k++) begin
        b.pos_a = some_pos(); b.quat_a = some_quat();
        b.pos_b = some_pos(); b.quat_b = some_quat();
        pending_bodies.push_back(b);
      end
      if (ph == 2) begin
        repeat (20) @(posedge clk_i);
        long_stall_req = 1'b1;
      end
      if (ph == 4) begin
        // pause the sender until the pipeline has emptied
        wait (pending_bodies.size() < 100);
        drive_hold = 1'b1;
        wait (expected_errs.size() == 0);
        drive_hold = 1'b0;
      end
      drain();
    end

    $display("sent %0d and checked %0d transactions over 8 register settings, with stalls and bursts",
             n_sent, n_checked);
    if (n_mismatch == 0 && expected_errs.size() == 0) begin
      $display("tb_cylindrical_joint_position_error_unit: done, clean");
    end else begin
      $display("tb_cylindrical_joint_position_error_unit: done, errors");
    end
    $finish;
  end

endmodule
